### rtl/mpa_pkg.sv
// Package for the signal phase arbiter: payload structs, register and policy codes,
// field widths and scoring constants. No dependencies.
`default_nettype none

package mpa_pkg;

	localparam int IO_LANES     = 4;
	localparam int ARR_W        = 6;
	localparam int Q_W          = 6;
	localparam int IDX_MAX_W    = 4;
	localparam int GREEN_W      = 2;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;
	localparam int PRIO_W       = 4;
	localparam int QUANT_W      = 8;
	localparam int STARVE_W     = 16;
	localparam int WAIT_OUT_W   = 16;
	localparam int TOT_S_W      = 32;
	localparam int TOT_W_W      = 40;
	localparam int HYBRID_BOOST = 15;
	localparam int PRIO_SCALE   = 5;

	typedef enum logic [1:0] {
		POL_RR,
		POL_STATIC,
		POL_AGING,
		POL_HYBRID
	} policy_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_POLICY,
		CFG_QUANTUM,
		CFG_PRIO_0,
		CFG_PRIO_1,
		CFG_PRIO_2,
		CFG_PRIO_3,
		CFG_QUEUE_LIMIT,
		CFG_STARVE_AGE
	} cfg_reg_t;

	typedef logic [IO_LANES-1:0][PRIO_W-1:0] prio_arr_t;

	typedef struct packed {
		logic [ARR_W-1:0] arrivals_0;
		logic [ARR_W-1:0] arrivals_1;
		logic [ARR_W-1:0] arrivals_2;
		logic [ARR_W-1:0] arrivals_3;
	} in_t;

	typedef struct packed {
		logic [GREEN_W-1:0]    green;
		logic                  switched;
		logic                  served_now;
		logic [WAIT_OUT_W-1:0] served_wait;
		logic [Q_W-1:0]        queue_0;
		logic [Q_W-1:0]        queue_1;
		logic [Q_W-1:0]        queue_2;
		logic [Q_W-1:0]        queue_3;
		logic [IO_LANES-1:0]   starve_mask;
		logic [TOT_S_W-1:0]    served_cnt;
		logic [TOT_W_W-1:0]    wait_cnt;
	} out_t;

	typedef struct packed {
		logic [IDX_MAX_W-1:0] next;
		logic [IDX_MAX_W-1:0] rr_next;
		logic [IO_LANES-1:0]  hyb_mask;
	} pick_t;

endpackage

`default_nettype wire

### rtl/mpa_queue_update.sv
// Per-approach arrival add, limit clamp and age advance for one tick.
// Depends on mpa_pkg.
`default_nettype none

module mpa_queue_update #(
	parameter int APPROACHES = 4,
	parameter int AGE_BITS   = 16
) (
	input  mpa_pkg::in_t            arrivals,
	input  logic [mpa_pkg::Q_W-1:0] queue_limit,
	input  logic [mpa_pkg::Q_W-1:0] queue_cur [APPROACHES],
	input  logic [AGE_BITS-1:0]     age_cur   [APPROACHES],
	output logic [mpa_pkg::Q_W-1:0] queue_new [APPROACHES],
	output logic [AGE_BITS-1:0]     age_new   [APPROACHES]
);
	import mpa_pkg::*;

	logic [IO_LANES-1:0][ARR_W-1:0] arr;

	assign arr = {arrivals.arrivals_3, arrivals.arrivals_2,
		arrivals.arrivals_1, arrivals.arrivals_0};

	always_comb begin
		logic [Q_W:0] sum;
		logic [ARR_W-1:0] a;
		for (int i = 0; i < APPROACHES; i++) begin
			a = (i < IO_LANES) ? arr[i % IO_LANES] : '0;
			sum = {1'b0, queue_cur[i]} + (Q_W+1)'(a);
			if (sum > {1'b0, queue_limit}) begin
				queue_new[i] = queue_limit;
			end else begin
				queue_new[i] = sum[Q_W-1:0];
			end
			if ((queue_new[i] != '0) && (age_cur[i] != '1)) begin
				age_new[i] = age_cur[i] + 1'b1;
			end else begin
				age_new[i] = age_cur[i];
			end
		end
	end

endmodule

`default_nettype wire

### rtl/mpa_policy_pick.sv
// Green selection for the four policies: round robin, static priority,
// aging score and hybrid score with starvation boost. Depends on mpa_pkg.
`default_nettype none

module mpa_policy_pick #(
	parameter int APPROACHES = 4,
	parameter int AGE_BITS   = 16,
	parameter int IW         = 2
) (
	input  mpa_pkg::policy_t             policy,
	input  mpa_pkg::prio_arr_t           prio,
	input  logic [mpa_pkg::STARVE_W-1:0] starve_age,
	input  logic [IW-1:0]                rr_pointer,
	input  logic [APPROACHES-1:0]        waiting,
	input  logic [AGE_BITS-1:0]          age [APPROACHES],
	output mpa_pkg::pick_t               pick
);
	import mpa_pkg::*;

	localparam int SW = AGE_BITS + 1;
	localparam int XW = (AGE_BITS > STARVE_W) ? AGE_BITS : STARVE_W;

	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] v);
		logic [IW:0] s;
		s = {1'b0, v} + 1'b1;
		if (s >= (IW+1)'(APPROACHES)) begin
			s = '0;
		end
		return s[IW-1:0];
	endfunction

	logic [IW-1:0]         rr_sel, rr_nxt, st_sel, sc_sel;
	logic [IO_LANES-1:0]   hmask;

	// round robin from the pointer
	always_comb begin
		logic found;
		logic [IW:0] idx;
		found  = 1'b0;
		rr_sel = wrap_inc(rr_pointer);
		rr_nxt = rr_sel;
		for (int k = 0; k < APPROACHES; k++) begin
			idx = {1'b0, rr_pointer} + (IW+1)'(k);
			if (idx >= (IW+1)'(APPROACHES)) begin
				idx = idx - (IW+1)'(APPROACHES);
			end
			if (!found && waiting[idx[IW-1:0]]) begin
				found  = 1'b1;
				rr_sel = idx[IW-1:0];
				rr_nxt = wrap_inc(idx[IW-1:0]);
			end
		end
	end

	// static priority, ties to the lowest index
	always_comb begin
		logic found;
		logic [PRIO_W-1:0] best_p, p;
		found  = 1'b0;
		best_p = '0;
		st_sel = '0;
		for (int i = 0; i < APPROACHES; i++) begin
			p = (i < IO_LANES) ? prio[i % IO_LANES] : '0;
			if (waiting[i] && (!found || (p > best_p))) begin
				found  = 1'b1;
				best_p = p;
				st_sel = IW'(i);
			end
		end
	end

	// aging or hybrid score: 5*prio + age, plus boost above starve_age (hybrid only)
	always_comb begin
		logic found;
		logic [SW-1:0] best_s, s;
		logic [PRIO_W-1:0] p;
		logic over;
		found  = 1'b0;
		best_s = '0;
		sc_sel = '0;
		hmask  = '0;
		for (int i = 0; i < APPROACHES; i++) begin
			p = (i < IO_LANES) ? prio[i % IO_LANES] : '0;
			s = SW'(p) * SW'(PRIO_SCALE) + SW'(age[i]);
			over = (XW'(age[i]) > XW'(starve_age)) && (policy == POL_HYBRID);
			if (over) begin
				s = s + SW'(HYBRID_BOOST);
				if (i < IO_LANES) begin
					hmask[i % IO_LANES] = 1'b1;
				end
			end
			if (waiting[i] && (!found || (s > best_s))) begin
				found  = 1'b1;
				best_s = s;
				sc_sel = IW'(i);
			end
		end
	end

	always_comb begin
		pick.rr_next  = IDX_MAX_W'(rr_nxt);
		pick.hyb_mask = hmask;
		unique case (policy)
			POL_RR:     pick.next = IDX_MAX_W'(rr_sel);
			POL_STATIC: pick.next = IDX_MAX_W'(st_sel);
			POL_AGING,
			POL_HYBRID: pick.next = IDX_MAX_W'(sc_sel);
			default:    pick.next = IDX_MAX_W'(sc_sel);
		endcase
	end

endmodule

`default_nettype wire

### rtl/multi_policy_signal_phase_arbiter.sv
// Signal phase arbiter top: config registers, arbiter state, serve and totals, result register.
// Result registered, valid in the cycle after input transfer. Throughput: one tick per cycle
// while in_ready holds, set by the combinational queue update, policy compare and serve path
// into the result register; a new input is taken whenever it is empty or being drained.
// Reset (arst_n low, asynchronous): queues, ages, green, quantum counter, round-robin pointer
// and totals clear; registers load policy 2, quantum 4, prio 4,3,2,1, limit 50, starve age 50.
`default_nettype none

module multi_policy_signal_phase_arbiter #(
	parameter int APPROACHES = 4,
	parameter int AGE_BITS   = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mpa_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [mpa_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  mpa_pkg::in_t                   in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output mpa_pkg::out_t                  out_data
);
	import mpa_pkg::*;

	localparam int IW = $clog2(APPROACHES);

	policy_t                policy_q;
	logic [QUANT_W-1:0]     quantum_q;
	prio_arr_t              prio_q;
	logic [Q_W-1:0]         qlimit_q;
	logic [STARVE_W-1:0]    starve_age_q;

	logic [Q_W-1:0]         queue_q [APPROACHES];
	logic [AGE_BITS-1:0]    age_q   [APPROACHES];
	logic [IW-1:0]          green_q;
	logic                   green_valid_q;
	logic [QUANT_W-1:0]     ticks_q;
	logic [IW-1:0]          rr_q;
	logic [TOT_S_W-1:0]     total_s_q;
	logic [TOT_W_W-1:0]     total_w_q;
	logic                   out_valid_q;
	out_t                   out_data_q;

	logic [Q_W-1:0]         queue_upd [APPROACHES];
	logic [AGE_BITS-1:0]    age_upd   [APPROACHES];
	logic [Q_W-1:0]         queue_fin [APPROACHES];
	logic [AGE_BITS-1:0]    age_fin   [APPROACHES];
	logic [APPROACHES-1:0]  waiting;
	pick_t                  pick;

	logic                   xfer_in;
	logic                   need;
	logic [IW-1:0]          g;
	logic                   serve;
	logic [AGE_BITS-1:0]    g_age;
	logic [IO_LANES-1:0]    mask;
	logic [QUANT_W-1:0]     ticks_d;
	logic [TOT_S_W-1:0]     total_s_d;
	logic [TOT_W_W-1:0]     total_w_d;
	logic [TOT_W_W:0]       wsum;
	logic [AGE_BITS+WAIT_OUT_W-1:0] g_age_ext;
	logic [IDX_MAX_W-1:0]   g_ext;
	out_t                   res;

	assign in_ready  = !out_valid_q || out_ready;
	assign xfer_in   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	mpa_queue_update #(
		.APPROACHES(APPROACHES),
		.AGE_BITS  (AGE_BITS)
	) u_queue (
		.arrivals   (in_data),
		.queue_limit(qlimit_q),
		.queue_cur  (queue_q),
		.age_cur    (age_q),
		.queue_new  (queue_upd),
		.age_new    (age_upd)
	);

	always_comb begin
		for (int i = 0; i < APPROACHES; i++) begin
			waiting[i] = (queue_upd[i] != '0);
		end
	end

	mpa_policy_pick #(
		.APPROACHES(APPROACHES),
		.AGE_BITS  (AGE_BITS),
		.IW        (IW)
	) u_pick (
		.policy    (policy_q),
		.prio      (prio_q),
		.starve_age(starve_age_q),
		.rr_pointer(rr_q),
		.waiting   (waiting),
		.age       (age_upd),
		.pick      (pick)
	);

	always_comb begin
		need  = !green_valid_q || (ticks_q == '0);
		g     = need ? pick.next[IW-1:0] : green_q;
		serve = waiting[g];
		g_age = age_upd[g];

		mask = (need && (policy_q == POL_HYBRID)) ? pick.hyb_mask : '0;
		if (need && green_valid_q && (g != green_q) && waiting[green_q]) begin
			for (int j = 0; j < IO_LANES; j++) begin
				if (int'(green_q) == j) begin
					mask[j] = 1'b1;
				end
			end
		end

		for (int i = 0; i < APPROACHES; i++) begin
			queue_fin[i] = queue_upd[i];
			age_fin[i]   = age_upd[i];
			if (serve && (int'(g) == i)) begin
				queue_fin[i] = queue_upd[i] - 1'b1;
				age_fin[i]   = '0;
			end
		end

		if (need) begin
			ticks_d = (quantum_q == '0) ? '0 : quantum_q - 1'b1;
		end else begin
			ticks_d = ticks_q - 1'b1;
		end

		// totals count served vehicles and sum their wait ages, both saturating
		total_s_d = total_s_q;
		total_w_d = total_w_q;
		wsum = {1'b0, total_w_q} + (TOT_W_W+1)'(g_age);
		if (serve) begin
			if (total_s_q != '1) begin
				total_s_d = total_s_q + 1'b1;
			end
			total_w_d = wsum[TOT_W_W] ? '1 : wsum[TOT_W_W-1:0];
		end

		g_age_ext = (AGE_BITS+WAIT_OUT_W)'(g_age);
		g_ext     = IDX_MAX_W'(g);

		res.green       = g_ext[GREEN_W-1:0];
		res.switched    = need;
		res.served_now  = serve;
		res.served_wait = serve ? g_age_ext[WAIT_OUT_W-1:0] : '0;
		res.queue_0     = (0 < APPROACHES) ? queue_fin[0 % APPROACHES] : '0;
		res.queue_1     = (1 < APPROACHES) ? queue_fin[1 % APPROACHES] : '0;
		res.queue_2     = (2 < APPROACHES) ? queue_fin[2 % APPROACHES] : '0;
		res.queue_3     = (3 < APPROACHES) ? queue_fin[3 % APPROACHES] : '0;
		res.starve_mask = mask;
		res.served_cnt  = total_s_d;
		res.wait_cnt    = total_w_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q     <= POL_AGING;
			quantum_q    <= QUANT_W'(4);
			prio_q       <= {PRIO_W'(1), PRIO_W'(2), PRIO_W'(3), PRIO_W'(4)};
			qlimit_q     <= Q_W'(50);
			starve_age_q <= STARVE_W'(50);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				CFG_POLICY:      policy_q     <= policy_t'(cfg_wdata[1:0]);
				CFG_QUANTUM:     quantum_q    <= cfg_wdata[QUANT_W-1:0];
				CFG_PRIO_0:      prio_q[0]    <= cfg_wdata[PRIO_W-1:0];
				CFG_PRIO_1:      prio_q[1]    <= cfg_wdata[PRIO_W-1:0];
				CFG_PRIO_2:      prio_q[2]    <= cfg_wdata[PRIO_W-1:0];
				CFG_PRIO_3:      prio_q[3]    <= cfg_wdata[PRIO_W-1:0];
				CFG_QUEUE_LIMIT: qlimit_q     <= cfg_wdata[Q_W-1:0];
				CFG_STARVE_AGE:  starve_age_q <= cfg_wdata[STARVE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < APPROACHES; i++) begin
				queue_q[i] <= '0;
				age_q[i]   <= '0;
			end
			green_q       <= '0;
			green_valid_q <= 1'b0;
			ticks_q       <= '0;
			rr_q          <= '0;
			total_s_q     <= '0;
			total_w_q     <= '0;
		end else if (xfer_in) begin
			for (int i = 0; i < APPROACHES; i++) begin
				queue_q[i] <= queue_fin[i];
				age_q[i]   <= age_fin[i];
			end
			green_q       <= g;
			green_valid_q <= 1'b1;
			ticks_q       <= ticks_d;
			if (need && (policy_q == POL_RR)) begin
				rr_q <= pick.rr_next[IW-1:0];
			end
			total_s_q <= total_s_d;
			total_w_q <= total_w_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (xfer_in) begin
			out_data_q <= res;
		end
	end

`ifndef SYNTHESIS
	a_xfer_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		xfer_in |=> out_valid)
		else $error("transfer accepted but no result registered");

	a_green_stays_valid: assert property (@(posedge clk) disable iff (!arst_n)
		green_valid_q |=> green_valid_q)
		else $error("green lost after first decision");

	a_first_tick_switches: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer_in && !green_valid_q) |=> out_data.switched)
		else $error("first tick made no scheduling decision");

	a_no_serve_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.served_now) |-> (out_data.served_wait == '0))
		else $error("served_wait nonzero without a served vehicle");
`endif

endmodule

`default_nettype wire
